>>> rtl/lattice_value_noise_3d_top_macros.svh
`ifndef LATTICE_VALUE_NOISE_3D_TOP_MACROS_SVH
`define LATTICE_VALUE_NOISE_3D_TOP_MACROS_SVH

// same-cycle implication
`define LVN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lvn check failed");

// next-cycle implication
`define LVN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lvn check failed");

`endif

>>> rtl/lvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lvn_pkg;

    localparam int LVN_TABLE_SIZE = 256;

    typedef enum logic [1:0] {
        CMD_LOAD_PERM  = 2'd0,
        CMD_LOAD_VALUE = 2'd1,
        CMD_SAMPLE     = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  addr;
        logic [15:0] data;
    } load_t;

    localparam logic [17:0] SMOOTH_T0    = 18'd196608;
    localparam logic [49:0] SMOOTH_ROUND = 50'h0_0000_8000_0000;

    function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] s);
        logic signed [16:0] d;
        logic signed [34:0] prod;
        logic signed [35:0] acc;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = d * $signed({1'b0, s});
        acc  = $signed({4'b0, a, 16'b0}) + 36'(prod) + 36'sd32768;
        if (acc[35:32] != 4'd0)
            return 16'hFFFF;
        return acc[31:16];
    endfunction

endpackage

`default_nettype wire

>>> rtl/lattice_value_noise_3d_top.sv
// each accepted sample transaction produces one noise_value, flagged by out_valid
// throughput: one transaction per cycle; the pipeline freezes only while a result is stalled
// table loads take effect in order with samples and give no result
// reset clears valid bits only; table contents are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

`include "lattice_value_noise_3d_top_macros.svh"

module lattice_value_noise_3d_top #(
    parameter int TABLE_SIZE = lvn_pkg::LVN_TABLE_SIZE
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  table_addr,
    input  wire logic [15:0] table_data,
    input  wire logic [31:0] coord_x,
    input  wire logic [31:0] coord_y,
    input  wire logic [31:0] coord_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      noise_value
);

    import lvn_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    logic          en;
    logic [8:1]    vld_reg;
    logic [8:1]    vld_next;
    load_t         ld_reg [1:4];
    load_t         ld_in;
    logic [IW-1:0] ix_reg [1:3];
    logic [IW-1:0] iy_reg;
    logic [IW-1:0] iz_in;
    logic [16:0]   sx3, sy3, sz3;
    logic [16:0]   sx_reg [4:5];
    logic [16:0]   sy_reg [4:6];
    logic [16:0]   sz_reg [4:7];
    logic [7:0]    pz [2];
    logic [7:0]    inner [2][2];
    logic [7:0]    h [2][2];
    logic [7:0]    hash [2][2][2];
    logic [15:0]   vv [2][2][2];
    logic [15:0]   e_reg [2][2];
    logic [15:0]   m_reg [2];
    logic [15:0]   res_reg;

    assign en       = !(vld_reg[8] && out_stall);
    assign in_stall = !en;
    assign ld_in    = '{cmd: cmd, addr: table_addr, data: table_data};
    assign iz_in    = coord_z[16 +: IW];

    always_comb
    begin
        vld_next    = {vld_reg[7:1], in_valid};
        vld_next[5] = vld_reg[4] && (ld_reg[4].cmd == CMD_SAMPLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ld_reg[1] <= ld_in;
            ld_reg[2] <= ld_reg[1];
            ld_reg[3] <= ld_reg[2];
            ld_reg[4] <= ld_reg[3];
            ix_reg[1] <= coord_x[16 +: IW];
            ix_reg[2] <= ix_reg[1];
            ix_reg[3] <= ix_reg[2];
            iy_reg    <= coord_y[16 +: IW];
            sx_reg[4] <= sx3;
            sx_reg[5] <= sx_reg[4];
            sy_reg[4] <= sy3;
            sy_reg[5] <= sy_reg[4];
            sy_reg[6] <= sy_reg[5];
            sz_reg[4] <= sz3;
            sz_reg[5] <= sz_reg[4];
            sz_reg[6] <= sz_reg[5];
            sz_reg[7] <= sz_reg[6];
            for (int y = 0; y < 2; y++)
                for (int z = 0; z < 2; z++)
                    e_reg[y][z] <= lerp(vv[0][y][z], vv[1][y][z], sx_reg[5]);
            for (int z = 0; z < 2; z++)
                m_reg[z] <= lerp(e_reg[0][z], e_reg[1][z], sy_reg[6]);
            res_reg <= lerp(m_reg[0], m_reg[1], sz_reg[7]);
        end
    end

    lvn_smooth u_smooth_x (.clk(clk), .en(en), .frac(coord_x[15:0]), .weight(sx3));
    lvn_smooth u_smooth_y (.clk(clk), .en(en), .frac(coord_y[15:0]), .weight(sy3));
    lvn_smooth u_smooth_z (.clk(clk), .en(en), .frac(coord_z[15:0]), .weight(sz3));

    // level 1: perm of z cell
    lvn_ram #(.DEPTH(TABLE_SIZE), .AW(IW), .DW(8)) u_perm_l1 (
        .clk       (clk),
        .en        (en),
        .wr_en     (en && in_valid && (cmd == CMD_LOAD_PERM)),
        .wr_addr   (IW'(table_addr)),
        .wr_data   (table_data[7:0]),
        .rd_addr_a (iz_in),
        .rd_addr_b (iz_in + IW'(1)),
        .rd_data_a (pz[0]),
        .rd_data_b (pz[1])
    );

    for (genvar z = 0; z < 2; z++)
    begin : g_l23
        // level 2: perm of y plus level 1
        lvn_ram #(.DEPTH(TABLE_SIZE), .AW(IW), .DW(8)) u_perm_l2 (
            .clk       (clk),
            .en        (en),
            .wr_en     (en && vld_reg[1] && (ld_reg[1].cmd == CMD_LOAD_PERM)),
            .wr_addr   (IW'(ld_reg[1].addr)),
            .wr_data   (ld_reg[1].data[7:0]),
            .rd_addr_a (iy_reg + IW'(pz[z])),
            .rd_addr_b (iy_reg + IW'(1) + IW'(pz[z])),
            .rd_data_a (inner[0][z]),
            .rd_data_b (inner[1][z])
        );
        // level 3: perm of inner hash
        lvn_ram #(.DEPTH(TABLE_SIZE), .AW(IW), .DW(8)) u_perm_l3 (
            .clk       (clk),
            .en        (en),
            .wr_en     (en && vld_reg[2] && (ld_reg[2].cmd == CMD_LOAD_PERM)),
            .wr_addr   (IW'(ld_reg[2].addr)),
            .wr_data   (ld_reg[2].data[7:0]),
            .rd_addr_a (IW'(inner[0][z])),
            .rd_addr_b (IW'(inner[1][z])),
            .rd_data_a (h[0][z]),
            .rd_data_b (h[1][z])
        );
    end

    for (genvar y = 0; y < 2; y++)
    begin : g_y
        for (genvar z = 0; z < 2; z++)
        begin : g_z
            // level 4: perm of x plus level 3
            lvn_ram #(.DEPTH(TABLE_SIZE), .AW(IW), .DW(8)) u_perm_l4 (
                .clk       (clk),
                .en        (en),
                .wr_en     (en && vld_reg[3] && (ld_reg[3].cmd == CMD_LOAD_PERM)),
                .wr_addr   (IW'(ld_reg[3].addr)),
                .wr_data   (ld_reg[3].data[7:0]),
                .rd_addr_a (ix_reg[3] + IW'(h[y][z])),
                .rd_addr_b (ix_reg[3] + IW'(1) + IW'(h[y][z])),
                .rd_data_a (hash[0][y][z]),
                .rd_data_b (hash[1][y][z])
            );
            lvn_ram #(.DEPTH(TABLE_SIZE), .AW(IW), .DW(16)) u_value (
                .clk       (clk),
                .en        (en),
                .wr_en     (en && vld_reg[4] && (ld_reg[4].cmd == CMD_LOAD_VALUE)),
                .wr_addr   (IW'(ld_reg[4].addr)),
                .wr_data   (ld_reg[4].data),
                .rd_addr_a (IW'(hash[0][y][z])),
                .rd_addr_b (IW'(hash[1][y][z])),
                .rd_data_a (vv[0][y][z]),
                .rd_data_b (vv[1][y][z])
            );
        end
    end

    assign out_valid   = vld_reg[8];
    assign noise_value = res_reg;

    `LVN_ASSERT_NOW(a_stalled_result_blocks_input, out_valid && out_stall, in_stall)
    `LVN_ASSERT_NEXT(a_accept_enters_pipe, in_valid && !in_stall, vld_reg[1])
    `LVN_ASSERT_NEXT(a_stall_freezes_pipe, in_stall, $stable(vld_reg))

endmodule

`default_nettype wire

>>> rtl/lvn_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lvn_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [DW-1:0] rd_data_a,
    output logic      [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lvn_smooth.sv
`timescale 1ns / 1ps
`default_nettype none

module lvn_smooth (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] frac,
    output logic      [16:0] weight
);

    import lvn_pkg::*;

    logic [31:0] ff_reg;
    logic [17:0] t_reg;
    logic [49:0] p_reg;
    logic [16:0] s_reg;
    logic [49:0] p_round;

    assign p_round = p_reg + SMOOTH_ROUND;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ff_reg <= 32'(frac) * 32'(frac);
            t_reg  <= SMOOTH_T0 - {1'b0, frac, 1'b0};
            p_reg  <= 50'(ff_reg) * 50'(t_reg);
            s_reg  <= p_round[48:32];
        end
    end

    assign weight = s_reg;

endmodule

`default_nettype wire
